// ----- design/sorted_table_prime_sidecross_assert.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef SORTED_TABLE_PRIME_SIDECROSS_ASSERT_SVH
`define SORTED_TABLE_PRIME_SIDECROSS_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define STP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/stp_pkg.sv -----
`default_nettype none
package stp_pkg;
    localparam int Capacity = 64;
    localparam int IdxW = 6;
    localparam int CntW = 7;

    typedef logic [1:0] action_t;
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_REMOVE = 2'd1;
    localparam action_t ACT_READ   = 2'd2;

    typedef logic [1:0] order_t;
    localparam order_t ORD_ASC   = 2'd0;
    localparam order_t ORD_PRIME = 2'd1;
    localparam order_t ORD_SIDE  = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_RANGE     = 2'd3;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic              ins;     // insert shift pass
        logic              del;     // remove shift pass
        logic signed [31:0] value;
        logic              pm;
        logic [IdxW-1:0]   del_idx;  // first equal index for remove
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE, S_PRIME, S_SCAN, S_UPDATE, S_READ, S_DONE
    } state_t;
endpackage
`default_nettype wire

// ----- design/stp_prime.sv -----
`default_nettype none
// Trial-division primality test: one restoring divide bit per cycle.
module stp_prime
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic signed [31:0] value,
    output logic                   done,
    output logic                   is_prime
);
    import stp_pkg::*;

    typedef enum logic [1:0] {P_IDLE, P_CHECK, P_DIV, P_NEXT} pstate_t;

    pstate_t     state_reg, state_next;
    logic [30:0] n_reg, n_next;
    logic [16:0] d_reg, d_next;
    logic [30:0] rem_reg, rem_next;
    logic [4:0]  bit_reg, bit_next;
    logic        done_reg, done_next;
    logic        prime_reg, prime_next;
    logic [33:0] sq;
    logic [31:0] trial;

    assign sq = {17'd0, d_reg} * {17'd0, d_reg};
    assign trial = {rem_reg, n_reg[bit_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        prime_reg <= prime_next;
    end

    // Square check, then a 31-step long division per divisor
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        prime_next = prime_reg;
        done_next = 1'b0;
        case (state_reg)
            P_IDLE:
            begin
                if (go)
                begin
                    n_next = value[30:0];
                    d_next = 17'd2;
                    if (value <= 32'sd1)
                    begin
                        prime_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                        state_next = P_CHECK;
                end
            end
            P_CHECK:
            begin
                if (sq > {3'd0, n_reg})
                begin
                    prime_next = 1'b1;
                    done_next = 1'b1;
                    state_next = P_IDLE;
                end
                else
                begin
                    rem_next = '0;
                    bit_next = 5'd30;
                    state_next = P_DIV;
                end
            end
            P_DIV:
            begin
                if (trial >= {15'd0, d_reg})
                    rem_next = 31'(trial - {15'd0, d_reg});
                else
                    rem_next = trial[30:0];
                if (bit_reg == 5'd0)
                    state_next = P_NEXT;
                else
                    bit_next = bit_reg - 5'd1;
            end
            P_NEXT:
            begin
                if (rem_reg == '0)
                begin
                    prime_next = 1'b0;
                    done_next = 1'b1;
                    state_next = P_IDLE;
                end
                else
                begin
                    d_next = d_reg + 17'd1;
                    state_next = P_CHECK;
                end
            end
            default: state_next = P_IDLE;
        endcase
    end

    assign done = done_reg;
    assign is_prime = prime_reg;
endmodule
`default_nettype wire

// ----- design/stp_cell.sv -----
`default_nettype none
// One table slot; takes its neighbor's entry during shift passes.
module stp_cell
(
    input  wire logic                      clk,
    input  wire logic [stp_pkg::IdxW-1:0]  idx,
    input  wire logic [stp_pkg::CntW-1:0]  count,
    input  wire stp_pkg::cell_cmd_t        cmd,
    input  wire logic signed [31:0]        left_val,
    input  wire logic                      left_pm,
    input  wire logic                      left_gt,
    input  wire logic signed [31:0]        right_val,
    input  wire logic                      right_pm,
    output logic signed [31:0]             val,
    output logic                           pm,
    output logic                           gt,
    output logic                           eq
);
    import stp_pkg::*;

    logic signed [31:0] val_reg;
    logic               pm_reg;
    logic               live;

    assign live = {1'b0, idx} < count;
    assign gt = live && (val_reg > cmd.value);
    assign eq = live && (val_reg == cmd.value);

    always_ff @(posedge clk)
    begin
        if (cmd.ins && ({1'b0, idx} <= count))
        begin
            // slot at count is empty; it takes the insert or its neighbor
            if (left_gt)
            begin
                val_reg <= left_val;
                pm_reg  <= left_pm;
            end
            else if (gt || ({1'b0, idx} == count))
            begin
                val_reg <= cmd.value;
                pm_reg  <= cmd.pm;
            end
        end
        else if (cmd.del && (idx >= cmd.del_idx))
        begin
            val_reg <= right_val;
            pm_reg  <= right_pm;
        end
    end

    assign val = val_reg;
    assign pm = pm_reg;
endmodule
`default_nettype wire

// ----- design/sorted_table_prime_sidecross.sv -----
`default_nettype none
// Sorted table of up to 64 signed values held in a row of cells. Assert
// start while busy is low; one result appears with done high for one cycle
// and must be taken then, since the receiver cannot stall. A full insert or
// a reserved action goes straight to the result, and a primes read walks
// the table one cell per cycle. An insert waits for the prime test, which
// tries one trial divisor after another up to sqrt(value); values below 2
// skip the test.
module sorted_table_prime_sidecross
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] value,
    input  wire logic [1:0]         order,
    input  wire logic [5:0]         position,
    output logic                    done,
    output logic signed [31:0]      read_value,
    output logic [1:0]              status,
    output logic [6:0]              count
);
    import stp_pkg::*;

    `include "sorted_table_prime_sidecross_assert.svh"

    state_t             state_reg, state_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    action_t            act_reg;
    order_t             ord_reg;
    logic signed [31:0] val_reg;
    logic [IdxW-1:0]    pos_reg;
    logic [IdxW-1:0]    scan_reg, scan_next;
    logic [IdxW:0]      seen_reg, seen_next;
    logic signed [31:0] rd_reg, rd_next;
    status_t            st_reg, st_next;
    logic               done_reg;
    logic               pm_reg;
    logic               prime_go, prime_done, prime_res;
    logic [IdxW-1:0]    del_idx_reg, del_idx_next;
    cell_cmd_t          cmd;

    logic signed [31:0] cv [Capacity];
    logic               cp [Capacity];
    logic               cg [Capacity];
    logic               ce [Capacity];
    logic [Capacity-1:0] eq_vec;
    logic [IdxW-1:0]    first_eq;
    logic               any_eq;
    logic [IdxW-1:0]    side_idx;

    // prime test starts at the accepting edge, so it takes the port value
    stp_prime u_prime
    (
        .clk(clk), .rst_n(rst_n), .go(prime_go), .value(value),
        .done(prime_done), .is_prime(prime_res)
    );

    // Row of cells
    for (genvar g = 0; g < Capacity; g++)
    begin : g_cell
        stp_cell u_cell
        (
            .clk(clk), .idx(IdxW'(g)), .count(cnt_reg), .cmd(cmd),
            .left_val(g == 0 ? 32'sd0 : cv[(g == 0) ? 0 : g - 1]),
            .left_pm(g == 0 ? 1'b0 : cp[(g == 0) ? 0 : g - 1]),
            .left_gt(g == 0 ? 1'b0 : cg[(g == 0) ? 0 : g - 1]),
            .right_val(cv[(g == Capacity - 1) ? g : g + 1]),
            .right_pm(cp[(g == Capacity - 1) ? g : g + 1]),
            .val(cv[g]), .pm(cp[g]), .gt(cg[g]), .eq(ce[g])
        );
        assign eq_vec[g] = ce[g];
    end

    // First equal entry, priority encoder
    always_comb
    begin
        first_eq = '0;
        for (int i = Capacity - 1; i >= 0; i--)
        begin
            if (eq_vec[i])
                first_eq = IdxW'(i);
        end
    end
    assign any_eq = |eq_vec;
    assign side_idx = pos_reg[0] ? IdxW'(cnt_reg - 7'd1 - {2'd0, pos_reg[5:1]})
                                 : {1'b0, pos_reg[5:1]};

    always_comb
    begin
        cmd.ins = (state_reg == S_UPDATE) && (act_reg == ACT_INSERT);
        cmd.del = (state_reg == S_UPDATE) && (act_reg == ACT_REMOVE);
        cmd.value = val_reg;
        cmd.pm = pm_reg;
        cmd.del_idx = del_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_next == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            act_reg <= action;
            ord_reg <= order;
            val_reg <= value;
            pos_reg <= position;
        end
        if (prime_done)
            pm_reg <= prime_res;
        scan_reg    <= scan_next;
        seen_reg    <= seen_next;
        rd_reg      <= rd_next;
        st_reg      <= st_next;
        del_idx_reg <= del_idx_next;
    end

    assign prime_go = (state_reg == S_IDLE) && start && (action == ACT_INSERT)
                      && ({1'b0, cnt_reg} < 8'(Capacity));

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        scan_next = scan_reg;
        seen_next = seen_reg;
        rd_next = rd_reg;
        st_next = st_reg;
        del_idx_next = del_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rd_next = '0;
                    st_next = ST_OK;
                    scan_next = '0;
                    seen_next = '0;
                    case (action)
                        ACT_INSERT:
                        begin
                            if ({1'b0, cnt_reg} >= 8'(Capacity))
                            begin
                                st_next = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_PRIME;
                        end
                        ACT_REMOVE: state_next = S_SCAN;
                        ACT_READ:   state_next = S_READ;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_PRIME:
            begin
                if (prime_done)
                    state_next = S_UPDATE;
            end
            S_SCAN:
            begin
                if (any_eq)
                begin
                    del_idx_next = first_eq;
                    state_next = S_UPDATE;
                end
                else
                begin
                    st_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
            end
            S_UPDATE:
            begin
                if (act_reg == ACT_INSERT)
                    cnt_next = cnt_reg + 7'd1;
                else
                    cnt_next = cnt_reg - 7'd1;
                state_next = S_DONE;
            end
            S_READ:
            begin
                state_next = S_DONE;
                st_next = ST_RANGE;
                case (ord_reg)
                    ORD_ASC:
                    begin
                        if ({1'b0, pos_reg} < cnt_reg)
                        begin
                            rd_next = cv[pos_reg];
                            st_next = ST_OK;
                        end
                    end
                    ORD_SIDE:
                    begin
                        if ({1'b0, pos_reg} < cnt_reg)
                        begin
                            rd_next = cv[side_idx];
                            st_next = ST_OK;
                        end
                    end
                    ORD_PRIME:
                    begin
                        // walk one cell per cycle
                        if ({1'b0, scan_reg} < cnt_reg)
                        begin
                            state_next = S_READ;
                            st_next = st_reg;
                            if (cp[scan_reg])
                            begin
                                if (seen_reg == {1'b0, pos_reg})
                                begin
                                    rd_next = cv[scan_reg];
                                    st_next = ST_OK;
                                    state_next = S_DONE;
                                end
                                seen_next = seen_reg + 7'd1;
                            end
                            scan_next = scan_reg + 6'd1;
                            if (scan_reg == IdxW'(Capacity - 1) && state_next == S_READ)
                            begin
                                st_next = ST_RANGE;
                                state_next = S_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign read_value = rd_reg;
    assign status = st_reg;
    assign count = cnt_reg;

    `STP_ASSERT_IMPL(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= 7'(Capacity),
        "count above capacity")
    `STP_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done,
        "result strobe longer than one cycle")
    `STP_ASSERT_IMPL(a_full_st, clk, rst_n, done && status == ST_FULL,
        count == 7'(Capacity), "full reported below capacity")
    `STP_ASSERT_IMPL(a_rd_zero, clk, rst_n, done && status != ST_OK,
        read_value == 32'sd0, "nonzero value on failed transaction")
endmodule
`default_nettype wire

// ----- sim/stp_checker.sv -----
// Watches the command and result channels of the sorted table, predicts
// each result from its own copy of the table and compares field by field.
module stp_checker
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] value,
    input  wire logic [1:0]         order,
    input  wire logic [5:0]         position,
    input  wire logic               done,
    input  wire logic signed [31:0] read_value,
    input  wire logic [1:0]         status,
    input  wire logic [6:0]         count,
    output int                      fail_count,
    output int                      pending
);
    import stp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] rd;
        status_t            st;
        logic [CntW-1:0]    cnt;
    } answer_t;

    // Shadow table in ascending order, with the prime mark per entry
    logic signed [31:0] table_vals[$];
    bit                 table_prime[$];
    answer_t            answers_due[$];

    // Trial division, squaring in 64 bits
    function automatic bit is_prime(logic signed [31:0] v);
        longint n;
        longint d;
        if (v <= 1)
            return 1'b0;
        n = longint'(v);
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one transaction to the shadow table and return its answer
    function automatic answer_t apply_command(action_t act, logic signed [31:0] v,
                                              order_t ord, logic [IdxW-1:0] pos);
        answer_t a;
        int      k;
        int      seen;
        int      n;
        a.rd = '0;
        a.st = ST_OK;
        n = table_vals.size();
        if (act == ACT_INSERT)
        begin
            if (n >= Capacity)
                a.st = ST_FULL;
            else
            begin
                k = n;
                while (k > 0 && table_vals[k-1] > v)
                    k--;
                table_vals.insert(k, v);
                table_prime.insert(k, is_prime(v));
            end
        end
        else if (act == ACT_REMOVE)
        begin
            a.st = ST_NOT_FOUND;
            for (k = 0; k < n; k++)
            begin
                if (table_vals[k] == v)
                begin
                    table_vals.delete(k);
                    table_prime.delete(k);
                    a.st = ST_OK;
                    break;
                end
            end
        end
        else if (act == ACT_READ)
        begin
            a.st = ST_RANGE;
            if (ord == ORD_ASC && pos < n)
            begin
                a.rd = table_vals[pos];
                a.st = ST_OK;
            end
            else if (ord == ORD_PRIME)
            begin
                seen = 0;
                for (k = 0; k < n; k++)
                begin
                    if (table_prime[k])
                    begin
                        if (seen == pos)
                        begin
                            a.rd = table_vals[k];
                            a.st = ST_OK;
                            break;
                        end
                        seen++;
                    end
                end
            end
            else if (ord == ORD_SIDE && pos < n)
            begin
                a.rd = pos[0] ? table_vals[n - 1 - (pos >> 1)] : table_vals[pos >> 1];
                a.st = ST_OK;
            end
        end
        a.cnt = CntW'(table_vals.size());
        return a;
    endfunction

    assign pending = answers_due.size();

    // Results are retired before the transaction of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("%0t: unexpected result value=%0d status=%0d count=%0d",
                                 $realtime, read_value, status, count);
                end
                else
                begin
                    exp_a = answers_due.pop_front();
                    if (read_value !== exp_a.rd || status !== exp_a.st || count !== exp_a.cnt)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"%0t: mismatch exp value=%0d status=%0d count=%0d,",
                                      " got value=%0d status=%0d count=%0d"},
                                     $realtime, exp_a.rd, exp_a.st, exp_a.cnt,
                                     read_value, status, count);
                    end
                end
            end
            if (start && !busy)
                answers_due = {answers_due, apply_command(action, value, order, position)};
        end
    end
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import stp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandItems  = 1430;
    localparam int StallLimit = 6000000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic signed [31:0] value;
    logic [1:0]         order;
    logic [5:0]         position;
    logic               done;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         count;
    int                 fail_count;
    int                 pending;
    int                 stall_cycles;

    // Values believed present, used to aim removes at real entries and to size read positions
    logic signed [31:0] held_vals[$];

    sorted_table_prime_sidecross dut (.*);

    stp_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: cycles without any transaction or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one transaction and hold it until accepted
    task automatic issue(action_t act, logic signed [31:0] v, order_t ord,
                         logic [IdxW-1:0] pos);
        int k;
        action   <= act;
        value    <= v;
        order    <= ord;
        position <= pos;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (act == ACT_INSERT && held_vals.size() < Capacity)
            held_vals = {held_vals, v};
        else if (act == ACT_REMOVE)
        begin
            for (k = 0; k < held_vals.size(); k++)
            begin
                if (held_vals[k] == v)
                begin
                    held_vals.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic idle_gap(bit quiet);
        if (!quiet && $urandom_range(99) < 37)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Mostly small values; large positives are multiples of three so the
    // prime test stays short
    function automatic logic signed [31:0] pick_value();
        int unsigned u;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $signed(32'($urandom_range(300))) - 100;
        if (sel < 85)
            return $signed($urandom | 32'h8000_0000);
        u = $urandom_range(32'h7FFF_FFFF, 1000);
        return $signed(u - (u % 3));
    endfunction

    initial
    begin
        action_t         act;
        order_t          ord;
        logic [IdxW-1:0] pos;
        int              w;
        int              ins_w;
        bit              quiet;
        logic signed [31:0] v;
        start    <= 1'b0;
        action   <= ACT_INSERT;
        value    <= '0;
        order    <= ORD_ASC;
        position <= '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edges of the value range, duplicates, every order
        issue(ACT_READ, 0, ORD_ASC, 0);          // empty table
        issue(ACT_REMOVE, 5, ORD_ASC, 0);        // missing value
        issue(ACT_INSERT, 0, ORD_ASC, 0);
        issue(ACT_INSERT, 1, ORD_ASC, 0);
        issue(ACT_INSERT, 2, ORD_ASC, 0);
        issue(ACT_INSERT, 32'sh8000_0000, ORD_ASC, 0);
        issue(ACT_INSERT, 32'sh7FFF_FFFF, ORD_ASC, 0);   // largest prime
        issue(ACT_INSERT, 32'sh7FFF_FFFE, ORD_ASC, 0);
        issue(ACT_INSERT, 7, ORD_ASC, 0);
        issue(ACT_INSERT, 7, ORD_ASC, 0);                // equal entries
        issue(ACT_INSERT, 4, ORD_ASC, 0);
        issue(ACT_INSERT, -7, ORD_ASC, 0);
        issue(ACT_READ, 0, ORD_ASC, 0);
        issue(ACT_READ, 0, ORD_ASC, 6'd63);              // past the end
        issue(ACT_READ, 0, ORD_PRIME, 0);
        issue(ACT_READ, 0, ORD_PRIME, 3);
        issue(ACT_READ, 0, ORD_PRIME, 4);                // past the last prime
        issue(ACT_READ, 0, ORD_SIDE, 0);
        issue(ACT_READ, 0, ORD_SIDE, 1);
        issue(ACT_READ, 0, ORD_SIDE, 8);
        issue(ACT_READ, 0, order_t'(2'd3), 0);           // reserved order
        issue(action_t'(2'd3), 32'sh7FFF_FFFF, ORD_ASC, 0); // reserved action
        issue(ACT_REMOVE, 7, ORD_ASC, 0);
        issue(ACT_REMOVE, 32'sh8000_0000, ORD_ASC, 0);

        // Hold off until every result has come back; the last transaction
        // is predicted on the edge just seen
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Random: alternating fill-heavy and drain-heavy phases
        for (int i = 0; i < RandItems; i++)
        begin
            quiet = (i >= 400 && i < 650);
            idle_gap(quiet);
            ins_w = ((i / 120) % 2 == 0) ? 60 : 20;
            w = $urandom_range(99);
            if (w < ins_w)
                act = ACT_INSERT;
            else if (w < 75)
                act = ACT_REMOVE;
            else if (w < 97)
                act = ACT_READ;
            else
                act = action_t'(2'd3);
            v = pick_value();
            if (act == ACT_REMOVE && held_vals.size() > 0 && $urandom_range(3) != 0)
                v = held_vals[$urandom_range(held_vals.size() - 1)];
            ord = order_t'($urandom_range(3));
            if ($urandom_range(3) == 0)
                pos = IdxW'($urandom);
            else
                pos = IdxW'($urandom_range(held_vals.size() + 1));
            issue(act, v, ord, pos);
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
